/* rtl/core/tilt_compensated_compass_heading_core_assert.svh */
// assertion macros for the compass heading core
// no dependencies
`ifndef TILT_COMPENSATED_COMPASS_HEADING_CORE_ASSERT_SVH
`define TILT_COMPENSATED_COMPASS_HEADING_CORE_ASSERT_SVH
`ifndef SYNTH
`define TCH_ASSERT(lbl, clkx, rstx, prop, msg) \
    lbl: assert property (@(posedge clkx) disable iff (!rstx) prop) else $error(msg);
`define TCH_ASSERT_NR(lbl, clkx, prop, msg) \
    lbl: assert property (@(posedge clkx) prop) else $error(msg);
`else
`define TCH_ASSERT(lbl, clkx, rstx, prop, msg)
`define TCH_ASSERT_NR(lbl, clkx, prop, msg)
`endif
`endif

/* rtl/core/tcch_pkg.sv */
// shared types and constants for the compass heading core
// no dependencies
package tcch_pkg;
    localparam int AngW = 16;
    localparam int CorW = 34;
    localparam int ZW = 26;
    localparam int VecW = 44;
    localparam int HeadW = 16;
    localparam logic signed [AngW-1:0] Deg180 = 16'sd23040;
    localparam logic signed [AngW-1:0] Deg90 = 16'sd11520;
    localparam logic [HeadW-1:0] Deg360 = 16'd46080;
    localparam logic signed [CorW-1:0] CordicK = 34'sd652032874;
    localparam logic signed [ZW-1:0] ZHalfTurn = 26'sd11796480;
    localparam logic [15:0] ScaleOne = 16'd16384;
    localparam logic [15:0] ScaleFbY = 16'd21791;

    typedef enum logic [2:0] {
        REG_ENABLED   = 3'd0,
        REG_CAL_VALID = 3'd1,
        REG_OFFSET_X  = 3'd2,
        REG_OFFSET_Y  = 3'd3,
        REG_OFFSET_Z  = 3'd4,
        REG_SCALE_X   = 3'd5,
        REG_SCALE_Y   = 3'd6
    } reg_idx_t;

    typedef enum logic [1:0] {
        SRC_COMPUTED = 2'd0,
        SRC_FALLBACK = 2'd1,
        SRC_DISABLED = 2'd2
    } src_t;

    typedef struct packed {
        src_t        src;
        logic [15:0] head;
    } side_t;

    function automatic logic signed [ZW-1:0] atan_entry(input int i);
        logic signed [ZW-1:0] r;
        begin
            unique case (i)
                0: r = 26'sd2949120;  1: r = 26'sd1740967;  2: r = 26'sd919879;
                3: r = 26'sd466945;   4: r = 26'sd234379;   5: r = 26'sd117304;
                6: r = 26'sd58666;    7: r = 26'sd29335;    8: r = 26'sd14668;
                9: r = 26'sd7334;     10: r = 26'sd3667;    11: r = 26'sd1833;
                12: r = 26'sd917;     13: r = 26'sd458;     14: r = 26'sd229;
                15: r = 26'sd115;     16: r = 26'sd57;      17: r = 26'sd29;
                18: r = 26'sd14;      19: r = 26'sd7;       20: r = 26'sd4;
                21: r = 26'sd2;       22: r = 26'sd1;       default: r = '0;
            endcase
            return r;
        end
    endfunction
endpackage

/* rtl/core/tcch_sincos.sv */
// pipelined rotation cordic, one stage per step, sine and cosine in q16
// depends on tcch_pkg
module tcch_sincos
    import tcch_pkg::*;
#(
    parameter int STEPS = 16
)(
    input  logic                    clk,
    input  logic                    en,
    input  logic signed [AngW-1:0]  angle,
    output logic signed [17:0]      sin_q16,
    output logic signed [17:0]      cos_q16
);
    localparam int N = (STEPS > 24) ? 24 : STEPS;

    logic signed [CorW-1:0] x_reg [N+1];
    logic signed [CorW-1:0] y_reg [N+1];
    logic signed [ZW-1:0]   z_reg [N+1];
    logic                   neg_reg [N+1];
    logic signed [AngW+1:0] a_w;
    logic signed [AngW+1:0] a_f;
    logic                   neg_w;
    logic signed [CorW-1:0] xo;
    logic signed [CorW-1:0] co;
    logic signed [CorW-1:0] so;

    always_comb
    begin
        a_w = {{2{angle[AngW-1]}}, angle};
        if (a_w >= 18'sd23040)
            a_w = a_w - 18'sd46080;
        if (a_w < -18'sd23040)
            a_w = a_w + 18'sd46080;
        neg_w = 1'b0;
        a_f = a_w;
        if (a_w > 18'sd11520)
        begin
            a_f = 18'sd23040 - a_w;
            neg_w = 1'b1;
        end
        else if (a_w < -18'sd11520)
        begin
            a_f = -18'sd23040 - a_w;
            neg_w = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0] <= CordicK;
            y_reg[0] <= '0;
            z_reg[0] <= ZW'(a_f) <<< 9;
            neg_reg[0] <= neg_w;
        end
    end

    for (genvar i = 0; i < N; i++)
    begin : g_step
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                neg_reg[i+1] <= neg_reg[i];
                if (!z_reg[i][ZW-1])
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - atan_entry(i);
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + atan_entry(i);
                end
            end
        end
    end

    always_comb
    begin
        xo = neg_reg[N] ? -x_reg[N] : x_reg[N];
        co = (xo + CorW'(8192)) >>> 14;
        so = (y_reg[N] + CorW'(8192)) >>> 14;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cos_q16 <= co[17:0];
            sin_q16 <= so[17:0];
        end
    end
endmodule

/* rtl/core/tcch_atan2.sv */
// pipelined vectoring cordic, atan2 in 1/128 degree wrapped to one turn
// depends on tcch_pkg
module tcch_atan2
    import tcch_pkg::*;
#(
    parameter int STEPS = 16
)(
    input  logic                    clk,
    input  logic                    en,
    input  logic signed [63:0]      y_in,
    input  logic signed [63:0]      x_in,
    output logic [HeadW-1:0]        head
);
    localparam int N = (STEPS > 24) ? 24 : STEPS;

    logic signed [63:0]     xs_reg;
    logic signed [63:0]     ys_reg;
    logic                   zero_reg;
    logic [4:0]             sh_reg;
    logic signed [VecW-1:0] x_reg [N+1];
    logic signed [VecW-1:0] y_reg [N+1];
    logic signed [ZW-1:0]   z_reg [N+1];
    logic                   zr_reg [N+1];
    logic [4:0]             sh_w;
    logic signed [63:0]     xt;
    logic signed [63:0]     yt;
    logic signed [63:0]     xa;
    logic signed [63:0]     ya;
    logic signed [VecW-1:0] xn;
    logic signed [VecW-1:0] yn;
    logic signed [ZW-1:0]   zf;
    logic signed [ZW-1:0]   h;

    // shift amount so both magnitudes drop below 2^40
    always_comb
    begin
        sh_w = '0;
        xt = '0;
        yt = '0;
        for (int s = 24; s >= 1; s--)
        begin
            xt = x_in >>> (s - 1);
            yt = y_in >>> (s - 1);
            if (xt >= 64'sh100_0000_0000 || xt <= -64'sh100_0000_0000 ||
                yt >= 64'sh100_0000_0000 || yt <= -64'sh100_0000_0000)
            begin
                if (sh_w == 5'd0)
                    sh_w = 5'(s);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xs_reg <= x_in;
            ys_reg <= y_in;
            sh_reg <= sh_w;
            zero_reg <= (x_in == 64'sd0) && (y_in == 64'sd0);
        end
    end

    always_comb
    begin
        xa = xs_reg >>> sh_reg;
        ya = ys_reg >>> sh_reg;
        xn = xa[VecW-1:0];
        yn = ya[VecW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zr_reg[0] <= zero_reg;
            if (xn[VecW-1])
            begin
                x_reg[0] <= -xn;
                y_reg[0] <= -yn;
                z_reg[0] <= ZHalfTurn;
            end
            else
            begin
                x_reg[0] <= xn;
                y_reg[0] <= yn;
                z_reg[0] <= '0;
            end
        end
    end

    for (genvar i = 0; i < N; i++)
    begin : g_step
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                zr_reg[i+1] <= zr_reg[i];
                if (y_reg[i] > 0)
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + atan_entry(i);
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - atan_entry(i);
                end
            end
        end
    end

    always_comb
    begin
        zf = (z_reg[N] + ZW'(256)) >>> 9;
        h = zf;
        if (zf < 0)
            h = zf + ZW'(46080);
        if (h >= ZW'(46080))
            h = h - ZW'(46080);
    end

    always_ff @(posedge clk)
    begin
        if (en)
            head <= zr_reg[N] ? '0 : h[HeadW-1:0];
    end
endmodule

/* rtl/core/tilt_compensated_compass_heading_core.sv */
// channel   dir  payload (low bit up)
// s_axis    in   tdata: roll, pitch, mag_x, mag_y, mag_z, attitude_valid, field_valid, fallback
// m_axis    out  tdata: heading, source
// cfg       in   index (3 bits), data (24 bits)
// sincos cordics, then products and sums, then the atan2 cordic (steps capped at 24)
// one transaction per cycle while m_axis does not stall, set by the fully pipelined cordic stages
// rst_n clears valid bits and config registers, scales reset to one; cfg is always ready
// a stall at m_axis freezes the whole pipeline, nothing is lost or repeated
// depends on tcch_pkg, tcch_sincos, tcch_atan2, assert header
`include "tilt_compensated_compass_heading_core_assert.svh"
module tilt_compensated_compass_heading_core
    import tcch_pkg::*;
#(
    parameter int CORDIC_STEPS = 16,
    parameter int FIELD_BITS = 18
)(
    input  logic clk,
    input  logic rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // roll[15:0], pitch, mag_x, mag_y, mag_z, attitude_valid, field_valid, fallback_heading
    input  logic [((50+3*FIELD_BITS)+7)/8*8-1:0] s_axis_tdata,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // heading[15:0], source[17:16]
    output logic [23:0] m_axis_tdata,
    input  logic cfg_valid,
    output logic cfg_ready,
    input  logic [2:0] cfg_index,
    input  logic [23:0] cfg_data
);
    localparam int FB = FIELD_BITS;
    localparam int NS = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
    localparam int LAT = 2 * NS + 8;
    localparam int SC = NS + 2;
    localparam int PW = FB + 18;
    localparam int MW = PW + 19;

    logic en;
    logic enabled_reg;
    logic cal_valid_reg;
    logic signed [FB-1:0] off_x_reg;
    logic signed [FB-1:0] off_y_reg;
    logic signed [FB-1:0] off_z_reg;
    logic [15:0] scale_x_reg;
    logic [15:0] scale_y_reg;

    logic signed [15:0] roll;
    logic signed [15:0] pitch;
    logic signed [FB-1:0] mx;
    logic signed [FB-1:0] my;
    logic signed [FB-1:0] mz;
    logic att_v;
    logic fld_v;
    logic [15:0] fallback;

    logic vld_reg [LAT+1];
    side_t side_reg [LAT+1];
    side_t side_in;
    logic signed [FB:0] dx_reg;
    logic signed [FB:0] dy_reg;
    logic signed [FB:0] dz_reg;
    logic [15:0] sx_reg;
    logic [15:0] sy_reg;
    logic signed [PW-1:0] xc_reg [SC+1];
    logic signed [PW-1:0] yc_reg [SC+1];
    logic signed [PW-1:0] zc_reg [SC+1];
    logic signed [17:0] sr;
    logic signed [17:0] cr;
    logic signed [17:0] sp;
    logic signed [17:0] cp;
    logic signed [35:0] srsp_p_reg;
    logic signed [35:0] srcp_p_reg;
    logic signed [17:0] cr_d_reg;
    logic signed [17:0] cp_d_reg;
    logic signed [17:0] sp_d_reg;
    logic signed [17:0] srsp_reg;
    logic signed [17:0] srcp_reg;
    logic signed [17:0] cr_d2_reg;
    logic signed [17:0] cp_d2_reg;
    logic signed [17:0] sp_d2_reg;
    logic signed [MW-1:0] t1_reg;
    logic signed [MW-1:0] t2_reg;
    logic signed [MW-1:0] t3_reg;
    logic signed [MW-1:0] t4_reg;
    logic signed [MW-1:0] t5_reg;
    logic signed [63:0] hx_reg;
    logic signed [63:0] hy_reg;
    logic signed [35:0] srsp_r;
    logic signed [35:0] srcp_r;
    logic [15:0] head_w;

    assign roll     = s_axis_tdata[15:0];
    assign pitch    = s_axis_tdata[31:16];
    assign mx       = s_axis_tdata[32+FB-1:32];
    assign my       = s_axis_tdata[32+2*FB-1:32+FB];
    assign mz       = s_axis_tdata[32+3*FB-1:32+2*FB];
    assign att_v    = s_axis_tdata[32+3*FB];
    assign fld_v    = s_axis_tdata[33+3*FB];
    assign fallback = s_axis_tdata[49+3*FB:34+3*FB];

    assign en = m_axis_tready || !m_axis_tvalid;
    assign s_axis_tready = en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg <= 1'b0;
            cal_valid_reg <= 1'b0;
            off_x_reg <= '0;
            off_y_reg <= '0;
            off_z_reg <= '0;
            scale_x_reg <= ScaleOne;
            scale_y_reg <= ScaleOne;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_ENABLED:   enabled_reg <= cfg_data[0];
                REG_CAL_VALID: cal_valid_reg <= cfg_data[0];
                REG_OFFSET_X:  off_x_reg <= cfg_data[FB-1:0];
                REG_OFFSET_Y:  off_y_reg <= cfg_data[FB-1:0];
                REG_OFFSET_Z:  off_z_reg <= cfg_data[FB-1:0];
                REG_SCALE_X:   scale_x_reg <= cfg_data[15:0];
                REG_SCALE_Y:   scale_y_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        if (!enabled_reg)
        begin
            side_in.src = SRC_DISABLED;
            side_in.head = '0;
        end
        else if (!att_v || !fld_v)
        begin
            side_in.src = SRC_FALLBACK;
            side_in.head = fallback;
        end
        else
        begin
            side_in.src = SRC_COMPUTED;
            side_in.head = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= LAT; i++)
                vld_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= s_axis_tvalid;
            for (int i = 1; i <= LAT; i++)
                vld_reg[i] <= vld_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side_in;
            for (int i = 1; i <= LAT; i++)
                side_reg[i] <= side_reg[i-1];
        end
    end

    // calibration: subtract offset, then scale x and y (fixed defaults while cal_valid is clear)
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (cal_valid_reg)
            begin
                dx_reg <= (FB+1)'(mx) - (FB+1)'(off_x_reg);
                dy_reg <= (FB+1)'(my) - (FB+1)'(off_y_reg);
                dz_reg <= (FB+1)'(mz) - (FB+1)'(off_z_reg);
                sx_reg <= scale_x_reg;
                sy_reg <= scale_y_reg;
            end
            else
            begin
                dx_reg <= (FB+1)'(mx) - (FB+1)'(64);
                dy_reg <= (FB+1)'(my) + (FB+1)'(80);
                dz_reg <= (FB+1)'(mz) + (FB+1)'(512);
                sx_reg <= ScaleOne;
                sy_reg <= ScaleFbY;
            end
            xc_reg[0] <= PW'(dx_reg) * $signed({1'b0, sx_reg});
            yc_reg[0] <= PW'(dy_reg) * $signed({1'b0, sy_reg});
            zc_reg[0] <= PW'(dz_reg) <<< 14;
            for (int i = 1; i <= SC; i++)
            begin
                xc_reg[i] <= xc_reg[i-1];
                yc_reg[i] <= yc_reg[i-1];
                zc_reg[i] <= zc_reg[i-1];
            end
        end
    end

    tcch_sincos #(.STEPS(CORDIC_STEPS)) u_roll (
        .clk(clk), .en(en), .angle(roll), .sin_q16(sr), .cos_q16(cr)
    );

    tcch_sincos #(.STEPS(CORDIC_STEPS)) u_pitch (
        .clk(clk), .en(en), .angle(pitch), .sin_q16(sp), .cos_q16(cp)
    );

    assign srsp_r = (srsp_p_reg + 36'sd32768) >>> 16;
    assign srcp_r = (srcp_p_reg + 36'sd32768) >>> 16;

    // registered products and sums follow the sincos outputs
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            srsp_p_reg <= sr * sp;
            srcp_p_reg <= sr * cp;
            cr_d_reg <= cr;
            cp_d_reg <= cp;
            sp_d_reg <= sp;
            srsp_reg <= srsp_r[17:0];
            srcp_reg <= srcp_r[17:0];
            cr_d2_reg <= cr_d_reg;
            cp_d2_reg <= cp_d_reg;
            sp_d2_reg <= sp_d_reg;
            t1_reg <= MW'(xc_reg[SC]) * MW'(cp_d2_reg);
            t2_reg <= MW'(zc_reg[SC]) * MW'(sp_d2_reg);
            t3_reg <= MW'(xc_reg[SC]) * MW'(srsp_reg);
            t4_reg <= MW'(yc_reg[SC]) * MW'(cr_d2_reg);
            t5_reg <= MW'(zc_reg[SC]) * MW'(srcp_reg);
            hx_reg <= 64'(t1_reg) + 64'(t2_reg);
            hy_reg <= 64'(t3_reg) + 64'(t4_reg) - 64'(t5_reg);
        end
    end

    tcch_atan2 #(.STEPS(CORDIC_STEPS)) u_atan (
        .clk(clk), .en(en), .y_in(hy_reg), .x_in(hx_reg), .head(head_w)
    );

    assign m_axis_tvalid = vld_reg[LAT];
    assign m_axis_tdata = {6'd0, side_reg[LAT].src,
        (side_reg[LAT].src == SRC_COMPUTED) ? head_w : side_reg[LAT].head};

    `TCH_ASSERT(a_disabled_zero, clk, rst_n,
        (m_axis_tvalid && m_axis_tdata[17:16] == SRC_DISABLED) |-> (m_axis_tdata[15:0] == 16'd0),
        "disabled result carries nonzero heading")
    `TCH_ASSERT(a_computed_range, clk, rst_n,
        (m_axis_tvalid && m_axis_tdata[17:16] == SRC_COMPUTED) |-> (m_axis_tdata[15:0] < Deg360),
        "computed heading out of range")
    `TCH_ASSERT(a_stall_hold, clk, rst_n,
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)),
        "stalled result changed")
    `TCH_ASSERT(a_src_code, clk, rst_n,
        m_axis_tvalid |-> (m_axis_tdata[17:16] != 2'd3),
        "invalid source code")
endmodule
